// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: rtl/aarm_pkg.sv
// ----------------------------------------------------------------------------
// aarm_pkg
// Shared constants and types for the axis-angle rotation matrix unit.
// ----------------------------------------------------------------------------
`default_nettype none
package aarm_pkg;
    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS = 31;
    localparam longint Q30_ONE = 64'sd1 << 30;
    localparam longint CORDIC_GAIN = 64'sd652032874;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    typedef logic signed [63:0] q_t;

    function automatic q_t atan_step(input int i);
        q_t r;
        r = '0;
        case (i)
            0: r = 64'sd843314857;
            1: r = 64'sd497837829;
            2: r = 64'sd263043837;
            3: r = 64'sd133525159;
            4: r = 64'sd67021687;
            5: r = 64'sd33543516;
            6: r = 64'sd16775851;
            7: r = 64'sd8388437;
            8: r = 64'sd4194283;
            9: r = 64'sd2097149;
            default: r = q_t'(64'sd1 <<< (30 - i));
        endcase
        return r;
    endfunction

    function automatic q_t clamp_one(input q_t v);
        q_t r;
        r = v;
        if (v > Q30_ONE) r = Q30_ONE;
        if (v < -Q30_ONE) r = -Q30_ONE;
        return r;
    endfunction

    // Q30 product, round half up; operands are within +-2^31
    function automatic q_t mul30(input q_t a, input q_t b);
        logic signed [33:0] aa;
        logic signed [33:0] bb;
        logic signed [67:0] p;
        aa = a[33:0];
        bb = b[33:0];
        p = aa * bb + 68'sd536870912;
        return q_t'(p >>> 30);
    endfunction
endpackage
`default_nettype wire

// File: rtl/aarm_cordic_cell.sv
// ----------------------------------------------------------------------------
// aarm_cordic_cell
// One CORDIC micro-rotation stage with a fixed shift and arctangent step.
// ----------------------------------------------------------------------------
`default_nettype none
module aarm_cordic_cell
    import aarm_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire  clk,
    input  wire  rst_n,
    input  wire  vin,
    input  q_t   xin,
    input  q_t   yin,
    input  q_t   zin,
    output logic vout,
    output q_t   xout,
    output q_t   yout,
    output q_t   zout
);
    q_t x_next, y_next, z_next;
    logic v_reg;
    q_t x_reg, y_reg, z_reg;

    always_comb
    begin
        if (!zin[63])
        begin
            x_next = xin - (yin >>> STEP);
            y_next = yin + (xin >>> STEP);
            z_next = zin - atan_step(STEP);
        end
        else
        begin
            x_next = xin + (yin >>> STEP);
            y_next = yin - (xin >>> STEP);
            z_next = zin + atan_step(STEP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign vout = v_reg;
    assign xout = x_reg;
    assign yout = y_reg;
    assign zout = z_reg;
endmodule
`default_nettype wire

// File: rtl/aarm_sqrt_cell.sv
// ----------------------------------------------------------------------------
// aarm_sqrt_cell
// One stage of a restoring integer square root, two radicand bits per cell.
// ----------------------------------------------------------------------------
`default_nettype none
module aarm_sqrt_cell
    import aarm_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         vin,
    input  logic [63:0] rem_in,
    input  logic [63:0] res_in,
    output logic        vout,
    output logic [63:0] rem_out,
    output logic [63:0] res_out
);
    localparam int SH = 2 * (SQRT_STEPS - 1 - STEP);
    logic [63:0] bitv, trial, rem_next, res_next;
    logic v_reg;
    logic [63:0] rem_reg, res_reg;

    assign bitv = 64'd1 << SH;
    assign trial = res_in + bitv;

    always_comb
    begin
        if (rem_in >= trial)
        begin
            rem_next = rem_in - trial;
            res_next = (res_in >> 1) + bitv;
        end
        else
        begin
            rem_next = rem_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign vout = v_reg;
    assign rem_out = rem_reg;
    assign res_out = res_reg;
endmodule
`default_nettype wire

// File: rtl/aarm_div_cell.sv
// ----------------------------------------------------------------------------
// aarm_div_cell
// One restoring division stage for the three axis components in parallel.
// ----------------------------------------------------------------------------
`default_nettype none
module aarm_div_cell
    import aarm_pkg::*;
#(
    parameter int STEP = 0
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         vin,
    input  logic [63:0] den_in,
    input  logic [63:0] num_in [3],
    input  logic [31:0] quo_in [3],
    output logic        vout,
    output logic [63:0] den_out,
    output logic [63:0] num_out [3],
    output logic [31:0] quo_out [3]
);
    // Quotient bit weight for this stage
    localparam int SH = DIV_STEPS - 1 - STEP;
    logic [63:0] num_next [3];
    logic [31:0] quo_next [3];
    logic [95:0] dsh;
    logic v_reg;
    logic [63:0] den_reg;
    logic [63:0] num_reg [3];
    logic [31:0] quo_reg [3];

    assign dsh = {32'd0, den_in} << SH;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if ({32'd0, num_in[k]} >= dsh)
            begin
                num_next[k] = num_in[k] - dsh[63:0];
                quo_next[k] = quo_in[k] | (32'd1 << SH);
            end
            else
            begin
                num_next[k] = num_in[k];
                quo_next[k] = quo_in[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_in;
        num_reg <= num_next;
        quo_reg <= quo_next;
    end

    assign vout = v_reg;
    assign den_out = den_reg;
    assign num_out = num_reg;
    assign quo_out = quo_reg;
endmodule
`default_nettype wire

// File: rtl/axis_angle_rotation_matrix_unit.sv
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_unit
// Axis-angle to column-major 4x4 rotation matrix, Q1.14 entries.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy rises after
// acceptance and falls when its gap counter runs out, so the unit does not take
// a new item until then. Entries appear in index order 0..15 with strobe
// high for exactly one cycle each, is_last on entry 15; the receiver cannot
// stall. The path from acceptance to the first entry runs through the chain of
// square root (31), divide (31), CORDIC (30) cells plus the input, unit vector,
// product and output registers. The chain is pipelined, so a new item enters
// while earlier ones still flow.
`default_nettype none
`include "assert_macros.svh"
module axis_angle_rotation_matrix_unit
    import aarm_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int VALUE_BITS = 16
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    output logic                        busy,
    input  wire  [15:0]                 angle_turns,
    input  wire  signed [15:0]          axis_x,
    input  wire  signed [15:0]          axis_y,
    input  wire  signed [15:0]          axis_z,
    output logic                        strobe,
    output logic [3:0]                  element_index,
    output logic signed [VALUE_BITS-1:0] element_value,
    output logic                        is_last
);
    localparam int AB = ANGLE_BITS;
    localparam int DLY = SQRT_STEPS + DIV_STEPS;
    localparam int OUT_SH = 32 - VALUE_BITS;

    typedef struct packed {
        logic [15:0] angle;
        logic        zero;
        logic [2:0]  neg;
        logic [15:0] mag_x;
        logic [15:0] mag_y;
        logic [15:0] mag_z;
    } side_t;

    logic accept;
    logic [3:0] gap_reg, gap_next;
    logic busy_reg, busy_next;
    assign accept = start && !busy_reg;
    assign busy = busy_reg;

    // Input capture
    logic v0_reg;
    side_t s0_reg;
    logic [63:0] ss0_reg;
    logic signed [31:0] sqx, sqy, sqz;
    assign sqx = axis_x * axis_x;
    assign sqy = axis_y * axis_y;
    assign sqz = axis_z * axis_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            busy_reg <= 1'b0;
            gap_reg <= '0;
        end
        else
        begin
            v0_reg <= accept;
            busy_reg <= busy_next;
            gap_reg <= gap_next;
        end
    end

    always_comb
    begin
        gap_next = gap_reg;
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            gap_next = 4'd15;
        end
        else if (busy_reg)
        begin
            if (gap_reg == 4'd1)
                busy_next = 1'b0;
            gap_next = gap_reg - 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_reg.angle <= angle_turns;
            s0_reg.zero <= (axis_x == 16'sd0) && (axis_y == 16'sd0) && (axis_z == 16'sd0);
            s0_reg.neg <= {axis_z[15], axis_y[15], axis_x[15]};
            s0_reg.mag_x <= axis_x[15] ? 16'(-axis_x) : axis_x;
            s0_reg.mag_y <= axis_y[15] ? 16'(-axis_y) : axis_y;
            s0_reg.mag_z <= axis_z[15] ? 16'(-axis_z) : axis_z;
            ss0_reg <= (64'(unsigned'(sqx)) + 64'(unsigned'(sqy)) + 64'(unsigned'(sqz))) << 30;
        end
    end

    // Square root chain
    logic sv [SQRT_STEPS+1];
    logic [63:0] srem [SQRT_STEPS+1];
    logic [63:0] sres [SQRT_STEPS+1];
    assign sv[0] = v0_reg;
    assign srem[0] = ss0_reg;
    assign sres[0] = '0;
    for (genvar g = 0; g < SQRT_STEPS; g++)
    begin : g_sqrt
        aarm_sqrt_cell #(.STEP(g)) u_cell (
            .clk(clk), .rst_n(rst_n), .vin(sv[g]),
            .rem_in(srem[g]), .res_in(sres[g]),
            .vout(sv[g+1]), .rem_out(srem[g+1]), .res_out(sres[g+1])
        );
    end

    // Divide chain: numerator = mag << 45 + n/2
    logic dv [DIV_STEPS+1];
    logic [63:0] dden [DIV_STEPS+1];
    logic [63:0] dnum [DIV_STEPS+1][3];
    logic [31:0] dquo [DIV_STEPS+1][3];
    side_t side_line [DLY];
    assign dv[0] = sv[SQRT_STEPS];
    assign dden[0] = sres[SQRT_STEPS];
    assign dnum[0][0] = ({48'd0, side_line[SQRT_STEPS-1].mag_x} << 45) + (sres[SQRT_STEPS] >> 1);
    assign dnum[0][1] = ({48'd0, side_line[SQRT_STEPS-1].mag_y} << 45) + (sres[SQRT_STEPS] >> 1);
    assign dnum[0][2] = ({48'd0, side_line[SQRT_STEPS-1].mag_z} << 45) + (sres[SQRT_STEPS] >> 1);
    assign dquo[0][0] = '0;
    assign dquo[0][1] = '0;
    assign dquo[0][2] = '0;
    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_div
        aarm_div_cell #(.STEP(g)) u_cell (
            .clk(clk), .rst_n(rst_n), .vin(dv[g]), .den_in(dden[g]),
            .num_in(dnum[g]), .quo_in(dquo[g]),
            .vout(dv[g+1]), .den_out(dden[g+1]),
            .num_out(dnum[g+1]), .quo_out(dquo[g+1])
        );
    end

    // Carry side data alongside the arithmetic chain
    always_ff @(posedge clk)
    begin
        side_line[0] <= s0_reg;
        for (int k = 1; k < DLY; k++)
            side_line[k] <= side_line[k-1];
    end

    // Unit vector, signed and clamped
    logic uv_reg;
    q_t ux_reg, uy_reg, uz_reg;
    side_t su_reg;
    function automatic q_t sgn_unit(input logic [31:0] u, input logic neg);
        q_t m;
        m = (u > 32'(Q30_ONE)) ? Q30_ONE : q_t'({32'd0, u});
        return neg ? -m : m;
    endfunction

    // Angle reduction feeding the CORDIC
    logic [AB-1:0] ang_w;
    logic [1:0] quad;
    logic [AB-3:0] rem_ang;
    logic [AB+28:0] zprod;
    assign ang_w = AB'(su_reg.angle);
    assign quad = ang_w[AB-1:AB-2];
    assign rem_ang = ang_w[AB-3:0];
    assign zprod = (AB+29)'(rem_ang) * (AB+29)'(HALF_PI_Q30);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            uv_reg <= 1'b0;
        else
            uv_reg <= dv[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        su_reg <= side_line[DLY-1];
        ux_reg <= sgn_unit(dquo[DIV_STEPS][0], side_line[DLY-1].neg[0]);
        uy_reg <= sgn_unit(dquo[DIV_STEPS][1], side_line[DLY-1].neg[1]);
        uz_reg <= sgn_unit(dquo[DIV_STEPS][2], side_line[DLY-1].neg[2]);
    end

    logic cv [CORDIC_STEPS+1];
    q_t cx [CORDIC_STEPS+1];
    q_t cy [CORDIC_STEPS+1];
    q_t cz [CORDIC_STEPS+1];
    assign cv[0] = uv_reg;
    assign cx[0] = CORDIC_GAIN;
    assign cy[0] = '0;
    assign cz[0] = q_t'(zprod >> (AB - 2));
    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cordic
        aarm_cordic_cell #(.STEP(g)) u_cell (
            .clk(clk), .rst_n(rst_n), .vin(cv[g]),
            .xin(cx[g]), .yin(cy[g]), .zin(cz[g]),
            .vout(cv[g+1]), .xout(cx[g+1]), .yout(cy[g+1]), .zout(cz[g+1])
        );
    end

    // Unit vector, quadrant and zero flag ride alongside the CORDIC
    typedef struct packed {
        logic [1:0] quad;
        logic       zero;
        q_t         ux;
        q_t         uy;
        q_t         uz;
    } cside_t;
    cside_t cside [CORDIC_STEPS];
    always_ff @(posedge clk)
    begin
        cside[0] <= '{quad: quad, zero: su_reg.zero, ux: ux_reg, uy: uy_reg, uz: uz_reg};
        for (int k = 1; k < CORDIC_STEPS; k++)
            cside[k] <= cside[k-1];
    end

    // Stage A: sine, cosine and pair products
    q_t xc, yc, cos_a, sin_a;
    assign xc = clamp_one(cx[CORDIC_STEPS]);
    assign yc = clamp_one(cy[CORDIC_STEPS]);
    always_comb
    begin
        case (cside[CORDIC_STEPS-1].quad)
            2'd0: begin cos_a = xc; sin_a = yc; end
            2'd1: begin cos_a = -yc; sin_a = xc; end
            2'd2: begin cos_a = -xc; sin_a = -yc; end
            default: begin cos_a = yc; sin_a = -xc; end
        endcase
    end

    logic av_reg;
    cside_t as_reg;
    q_t c_reg, omc_reg, xx_reg, yy_reg, zz_reg, xy_reg, yz_reg, zx_reg;
    q_t xs_reg, ys_reg, zs_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            av_reg <= 1'b0;
        else
            av_reg <= cv[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        as_reg <= cside[CORDIC_STEPS-1];
        c_reg <= cos_a;
        omc_reg <= Q30_ONE - cos_a;
        xx_reg <= mul30(cside[CORDIC_STEPS-1].ux, cside[CORDIC_STEPS-1].ux);
        yy_reg <= mul30(cside[CORDIC_STEPS-1].uy, cside[CORDIC_STEPS-1].uy);
        zz_reg <= mul30(cside[CORDIC_STEPS-1].uz, cside[CORDIC_STEPS-1].uz);
        xy_reg <= mul30(cside[CORDIC_STEPS-1].ux, cside[CORDIC_STEPS-1].uy);
        yz_reg <= mul30(cside[CORDIC_STEPS-1].uy, cside[CORDIC_STEPS-1].uz);
        zx_reg <= mul30(cside[CORDIC_STEPS-1].uz, cside[CORDIC_STEPS-1].ux);
        xs_reg <= mul30(cside[CORDIC_STEPS-1].ux, sin_a);
        ys_reg <= mul30(cside[CORDIC_STEPS-1].uy, sin_a);
        zs_reg <= mul30(cside[CORDIC_STEPS-1].uz, sin_a);
    end

    // Stage B: Rodrigues entries into the output shift row
    function automatic logic [VALUE_BITS-1:0] to_out(input q_t v);
        q_t r, one;
        one = q_t'(64'sd1 <<< (VALUE_BITS - 2));
        if (OUT_SH == 0)
            r = v;
        else
            r = (v + q_t'(64'sd1 <<< (OUT_SH - 1))) >>> OUT_SH;
        if (r > one) r = one;
        if (r < -one) r = -one;
        return r[VALUE_BITS-1:0];
    endfunction

    q_t m_ent [16];
    always_comb
    begin
        for (int k = 0; k < 16; k++)
            m_ent[k] = '0;
        m_ent[15] = Q30_ONE;
        if (as_reg.zero)
        begin
            m_ent[0] = Q30_ONE;
            m_ent[5] = Q30_ONE;
            m_ent[10] = Q30_ONE;
        end
        else
        begin
            m_ent[0] = mul30(omc_reg, xx_reg) + c_reg;
            m_ent[4] = mul30(omc_reg, xy_reg) - zs_reg;
            m_ent[8] = mul30(omc_reg, zx_reg) + ys_reg;
            m_ent[1] = mul30(omc_reg, xy_reg) + zs_reg;
            m_ent[5] = mul30(omc_reg, yy_reg) + c_reg;
            m_ent[9] = mul30(omc_reg, yz_reg) - xs_reg;
            m_ent[2] = mul30(omc_reg, zx_reg) - ys_reg;
            m_ent[6] = mul30(omc_reg, yz_reg) + xs_reg;
            m_ent[10] = mul30(omc_reg, zz_reg) + c_reg;
        end
    end

    logic [VALUE_BITS-1:0] row_reg [16];
    logic out_busy_reg;
    logic [3:0] idx_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_busy_reg <= 1'b0;
            idx_reg <= '0;
        end
        else if (av_reg)
        begin
            out_busy_reg <= 1'b1;
            idx_reg <= '0;
        end
        else if (out_busy_reg)
        begin
            if (idx_reg == 4'd15)
                out_busy_reg <= 1'b0;
            idx_reg <= idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (av_reg)
        begin
            for (int k = 0; k < 16; k++)
                row_reg[k] <= to_out(m_ent[k]);
        end
        else
        begin
            // advance the row by one entry
            for (int k = 0; k < 15; k++)
                row_reg[k] <= row_reg[k+1];
            row_reg[15] <= '0;
        end
    end

    assign strobe = out_busy_reg;
    assign element_index = idx_reg;
    assign element_value = row_reg[0];
    assign is_last = out_busy_reg && (idx_reg == 4'd15);

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, accept, busy,
        "busy not raised after accept")
    `ASSERT_IMPL(a_last_strobe, clk, rst_n, is_last, strobe, "is_last without strobe")
    `ASSERT_IMPL(a_no_overlap, clk, rst_n, av_reg, !out_busy_reg || idx_reg == 4'd15,
        "new matrix while previous still streaming")
endmodule
`default_nettype wire

// File: tb/sv/axis_angle_rotation_matrix_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix_unit_tb
// Drives angle/axis commands with random gaps and checks all sixteen streamed
// matrix entries of each transaction against a fixed-point Rodrigues model
// built from an integer square root, a rounding divide and a 30-step CORDIC.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix_unit_tb;

    typedef struct packed {
        logic [15:0]        angle;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
    } rot_cmd_t;

    typedef struct packed {
        logic [3:0]         idx;
        logic signed [15:0] value;
        logic               last;
    } matrix_entry_t;

    localparam longint ONE_Q30   = 64'sd1 << 30;
    localparam int     IDLE_LIMIT = 4000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [15:0] angle_turns = '0;
    logic signed [15:0] axis_x = '0;
    logic signed [15:0] axis_y = '0;
    logic signed [15:0] axis_z = '0;
    wire busy;
    wire strobe;
    wire [3:0] element_index;
    wire signed [15:0] element_value;
    wire is_last;

    rot_cmd_t      cmd_queue[$];
    matrix_entry_t entry_queue[$];
    int            fail_count = 0;
    int            gap_left = 0;
    int            idle_cycles = 0;

    longint arctan_q30[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                               33543516, 16775851, 8388437, 4194283, 2097149};

    axis_angle_rotation_matrix_unit u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .angle_turns(angle_turns), .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z),
        .strobe(strobe), .element_index(element_index), .element_value(element_value),
        .is_last(is_last)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic longint q30_product(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v > ONE_Q30) return ONE_Q30;
        if (v < -ONE_Q30) return -ONE_Q30;
        return v;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_w;
        res = '0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    function automatic longint unit_component(input longint v, input logic [63:0] n);
        logic [63:0] mag;
        logic [63:0] u;
        mag = (v < 0) ? 64'(-v) : 64'(v);
        u = ((mag << 45) + n / 2) / n;
        if (u > 64'(ONE_Q30)) u = 64'(ONE_Q30);
        return (v < 0) ? -longint'(u) : longint'(u);
    endfunction

    function automatic logic signed [15:0] to_q14(input longint v);
        longint r;
        r = (v + (64'sd1 <<< 15)) >>> 16;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    task automatic push_expected_matrix(input rot_cmd_t c);
        longint m[16];
        longint ax, ay, az, ux, uy, uz, x, y, z, t, step, cs, sn, omc;
        longint xx, yy, zz, xy, yz, zx, xs, ys, zs;
        logic [63:0] ss, n;
        logic [1:0] quad;
        matrix_entry_t e;
        ax = c.ax;
        ay = c.ay;
        az = c.az;
        for (int k = 0; k < 16; k++) m[k] = 0;
        if (ax == 0 && ay == 0 && az == 0) begin
            m[0] = ONE_Q30;
            m[5] = ONE_Q30;
            m[10] = ONE_Q30;
        end else begin
            ss = 64'(ax * ax + ay * ay + az * az);
            n = int_sqrt(ss << 30);
            ux = unit_component(ax, n);
            uy = unit_component(ay, n);
            uz = unit_component(az, n);
            quad = c.angle[15:14];
            z = (longint'(c.angle[13:0]) * 64'sd1686629713) >>> 14;
            x = 64'sd652032874;
            y = 0;
            for (int i = 0; i < 30; i++) begin
                step = (i < 10) ? arctan_q30[i] : (64'sd1 <<< (30 - i));
                if (z >= 0) begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    z = z - step;
                end else begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    z = z + step;
                end
                x = t;
            end
            x = clamp_unit(x);
            y = clamp_unit(y);
            case (quad)
                2'd0: begin cs = x;  sn = y;  end
                2'd1: begin cs = -y; sn = x;  end
                2'd2: begin cs = -x; sn = -y; end
                default: begin cs = y; sn = -x; end
            endcase
            omc = ONE_Q30 - cs;
            xx = q30_product(ux, ux);
            yy = q30_product(uy, uy);
            zz = q30_product(uz, uz);
            xy = q30_product(ux, uy);
            yz = q30_product(uy, uz);
            zx = q30_product(uz, ux);
            xs = q30_product(ux, sn);
            ys = q30_product(uy, sn);
            zs = q30_product(uz, sn);
            m[0]  = q30_product(omc, xx) + cs;
            m[4]  = q30_product(omc, xy) - zs;
            m[8]  = q30_product(omc, zx) + ys;
            m[1]  = q30_product(omc, xy) + zs;
            m[5]  = q30_product(omc, yy) + cs;
            m[9]  = q30_product(omc, yz) - xs;
            m[2]  = q30_product(omc, zx) - ys;
            m[6]  = q30_product(omc, yz) + xs;
            m[10] = q30_product(omc, zz) + cs;
        end
        m[15] = ONE_Q30;
        for (int k = 0; k < 16; k++) begin
            e.idx = 4'(k);
            e.value = to_q14(m[k]);
            e.last = (k == 15);
            entry_queue.push_back(e);
        end
    endtask

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [15:0] pick_axis(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 16) - 8);
            default: return 16'($urandom_range(0, 16383) - 8192);
        endcase
    endfunction

    // stimulus: directed corners first, then random commands
    initial begin
        rot_cmd_t c;
        int mode;
        logic [15:0] corner_angles[6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                          16'hFFFF, 16'h2000};
        foreach (corner_angles[i]) begin
            cmd_queue.push_back('{corner_angles[i], 16'sh2000, 16'sh0, 16'sh0});
            cmd_queue.push_back('{corner_angles[i], 16'sh0, 16'sh0, 16'sh0});
        end
        cmd_queue.push_back('{16'h1234, -16'sd32768, -16'sd32768, -16'sd32768});
        cmd_queue.push_back('{16'h5555, 16'sd32767, 16'sd32767, 16'sd32767});
        cmd_queue.push_back('{16'hAAAA, 16'sd32767, -16'sd32768, 16'sd1});
        cmd_queue.push_back('{16'h0001, 16'sd1, 16'sd0, 16'sd0});
        cmd_queue.push_back('{16'h7FFF, 16'sd0, -16'sd1, 16'sd0});
        cmd_queue.push_back('{16'h3FFF, 16'sd0, 16'sd0, 16'sd32767});
        cmd_queue.push_back('{16'hE000, 16'sd1, 16'sd1, 16'sd1});
        cmd_queue.push_back('{16'h6000, -16'sd5793, 16'sd5793, 16'sd0});
        for (int i = 0; i < 320; i++) begin
            c.angle = 16'($urandom);
            mode = $urandom_range(0, 2);
            c.ax = pick_axis(mode);
            c.ay = pick_axis(mode);
            c.az = pick_axis(mode);
            case ($urandom_range(0, 9))
                0: begin c.ax = '0; c.ay = '0; c.az = '0; end
                1: begin c.ay = '0; c.az = '0; end
                2: c.ax = '0;
                default: ;
            endcase
            cmd_queue.push_back(c);
        end
    end

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver: hold start with the current command until it is taken
    always @(posedge clk) begin
        if (rst_n) begin
            if (start && !busy) begin
                push_expected_matrix(cmd_queue.pop_front());
                gap_left = pick_gap();
            end
            if ((start && busy) || (gap_left == 0 && cmd_queue.size() > 0)) begin
                if (!(start && busy)) begin
                    angle_turns <= cmd_queue[0].angle;
                    axis_x <= cmd_queue[0].ax;
                    axis_y <= cmd_queue[0].ay;
                    axis_z <= cmd_queue[0].az;
                end
                start <= 1'b1;
            end else begin
                if (gap_left > 0) gap_left--;
                start <= 1'b0;
            end
        end
    end

    // monitor: compare each entry with the oldest expected one
    always @(posedge clk) begin
        matrix_entry_t e;
        if (rst_n && strobe) begin
            if (entry_queue.size() == 0) begin
                $error("unexpected entry index %0d value %0d", element_index, element_value);
                fail_count++;
            end else begin
                e = entry_queue.pop_front();
                if (element_index !== e.idx) begin
                    $error("element_index expected %0d actual %0d", e.idx, element_index);
                    fail_count++;
                end
                if (element_value !== e.value) begin
                    $error("element_value expected %0d actual %0d", e.value, element_value);
                    fail_count++;
                end
                if (is_last !== e.last) begin
                    $error("is_last expected %0d actual %0d", e.last, is_last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || strobe || (start && !busy)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("axis_angle_rotation_matrix_unit: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (rst_n);
        @(posedge clk);
        wait (cmd_queue.size() == 0 && !start && entry_queue.size() == 0);
        repeat (200) @(posedge clk);
        if (fail_count == 0 && entry_queue.size() == 0)
            $display("axis_angle_rotation_matrix_unit: match");
        else
            $display("axis_angle_rotation_matrix_unit: mismatch");
        $finish;
    end

endmodule
